FILE: src/rip_pkg.sv
// Shared types and constants for the track rip checksum block.
package rip_pkg;

   localparam int unsigned SECTOR_BYTES = 2352;
   localparam int unsigned SKIP_SECTORS = 5;
   localparam int unsigned SKIP_WORDS_INT = (SECTOR_BYTES * SKIP_SECTORS) / 4;

   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam int unsigned CSR_DATA_WIDTH = 28;
   localparam int unsigned TRACK_WIDTH = 7;
   localparam int unsigned COUNT_WIDTH = 28;
   localparam int unsigned WORD_WIDTH = 32;
   localparam int unsigned SUM_WIDTH = 32;

   localparam logic [COUNT_WIDTH-1:0] SKIP_WORDS = COUNT_WIDTH'(SKIP_WORDS_INT);
   localparam logic [TRACK_WIDTH-1:0] FIRST_TRACK = TRACK_WIDTH'(1);

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_TRACK_INDEX  = 2'd0,
      CSR_TRACK_TOTAL  = 2'd1,
      CSR_SAMPLE_COUNT = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic in_window;
      logic track_end;
   } item_flags_type;

   typedef struct packed {
      logic result_push;
      logic result_full;
   } back_status_type;

endpackage

FILE: src/cd_track_rip_checksum.sv
// Top level of the track rip checksum block.
//
// Computes the v1 and v2 rip checksums of a track from a stream of 32-bit stereo
// sample words, one request per clock. Program track_index, track_total and
// sample_count before the first sample of a track; after the sample at position
// sample_count a single result with both checksums is queued and the block starts
// the next track at position 1. Requests are taken every cycle while req_full is
// low; a result passes to rsp_* through the four-entry queue between the
// classifier and the multiply-accumulate stage, the registered multiplier and
// the two-entry result queue, which lets samples keep flowing while a result
// waits to be popped; a track end waits in the item queue only while the
// result queue has no room for its result, and the input stalls once the item
// queue fills up behind it.
module cd_track_rip_checksum #(
   parameter int unsigned POSITION_WIDTH = 28
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [rip_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [rip_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic [rip_pkg::WORD_WIDTH-1:0]      req_sample_word,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic [rip_pkg::SUM_WIDTH-1:0]       rsp_checksum_v1,
   output logic [rip_pkg::SUM_WIDTH-1:0]       rsp_checksum_v2
);

   localparam int unsigned Q_DEPTH_LOG2 = 2;
   localparam int unsigned Q_WIDTH = rip_pkg::WORD_WIDTH + POSITION_WIDTH + 2;

   logic                            q_push, q_pop, q_full, q_empty;
   logic [rip_pkg::WORD_WIDTH-1:0]  f_word, b_word;
   logic [POSITION_WIDTH-1:0]       f_pos, b_pos;
   rip_pkg::item_flags_type         f_flags, b_flags;
   rip_pkg::back_status_type        back_status;

   rip_front #(
      .POSITION_WIDTH (POSITION_WIDTH)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_push        (req_push),
      .req_sample_word (req_sample_word),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_word          (f_word),
      .q_pos           (f_pos),
      .q_flags         (f_flags)
   );

   rip_fifo #(
      .WIDTH      (Q_WIDTH),
      .DEPTH_LOG2 (Q_DEPTH_LOG2)
   ) u_item_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data ({f_word, f_pos, f_flags}),
      .pop       (q_pop),
      .pop_data  ({b_word, b_pos, b_flags}),
      .full      (q_full),
      .empty     (q_empty)
   );

   rip_back #(
      .POSITION_WIDTH (POSITION_WIDTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_word          (b_word),
      .q_pos           (b_pos),
      .q_flags         (b_flags),
      .q_pop           (q_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_checksum_v1 (rsp_checksum_v1),
      .rsp_checksum_v2 (rsp_checksum_v2),
      .status          (back_status)
   );

   assign req_full = q_full;

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !req_full && rsp_empty)
      else $error("block not idle after reset");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("item queue popped while empty");

   a_result_room: assert property (@(posedge clock) disable iff (reset)
      back_status.result_push |-> !back_status.result_full)
      else $error("result pushed into full result queue");

   a_result_follows_end: assert property (@(posedge clock) disable iff (reset)
      back_status.result_push |-> $past(q_pop && b_flags.track_end))
      else $error("result without a track end");

endmodule

FILE: src/rip_fifo.sv
// Small register-based first-in first-out queue.
module rip_fifo #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH_LOG2 = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             empty
);

   localparam int unsigned DEPTH = 1 << DEPTH_LOG2;

   logic [WIDTH-1:0]      mem_ff [DEPTH];
   logic [DEPTH_LOG2-1:0] wr_ptr_ff, wr_ptr_in;
   logic [DEPTH_LOG2-1:0] rd_ptr_ff, rd_ptr_in;
   logic [DEPTH_LOG2:0]   count_ff, count_in;
   logic                  do_push, do_pop;

   assign full     = count_ff[DEPTH_LOG2];
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: src/rip_front.sv
// Front end: configuration registers, sample position counter and window classifier.
module rip_front #(
   parameter int unsigned POSITION_WIDTH = 28
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write_en,
   input  logic [rip_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [rip_pkg::CSR_DATA_WIDTH-1:0]     csr_wdata,
   input  logic                                   req_push,
   input  logic [rip_pkg::WORD_WIDTH-1:0]         req_sample_word,
   input  logic                                   q_full,
   output logic                                   q_push,
   output logic [rip_pkg::WORD_WIDTH-1:0]         q_word,
   output logic [POSITION_WIDTH-1:0]              q_pos,
   output rip_pkg::item_flags_type                q_flags
);

   localparam int unsigned CMP_WIDTH =
      ((POSITION_WIDTH > rip_pkg::COUNT_WIDTH) ? POSITION_WIDTH : rip_pkg::COUNT_WIDTH) + 1;

   logic [rip_pkg::TRACK_WIDTH-1:0] track_index_ff, track_index_in;
   logic [rip_pkg::TRACK_WIDTH-1:0] track_total_ff, track_total_in;
   logic [rip_pkg::COUNT_WIDTH-1:0] sample_count_ff, sample_count_in;
   logic [POSITION_WIDTH-1:0]       position_ff, position_in;

   logic [CMP_WIDTH-1:0]            pos_ext;
   logic [rip_pkg::COUNT_WIDTH-1:0] hi_bound;
   logic                            first_track, last_track, short_track;
   logic                            below_lo, above_hi, track_end;

   always_comb begin
      track_index_in  = track_index_ff;
      track_total_in  = track_total_ff;
      sample_count_in = sample_count_ff;
      if (csr_write_en) begin
         unique case (rip_pkg::csr_index_type'(csr_index))
            rip_pkg::CSR_TRACK_INDEX: begin
               track_index_in = csr_wdata[rip_pkg::TRACK_WIDTH-1:0];
            end
            rip_pkg::CSR_TRACK_TOTAL: begin
               track_total_in = csr_wdata[rip_pkg::TRACK_WIDTH-1:0];
            end
            rip_pkg::CSR_SAMPLE_COUNT: begin
               sample_count_in = csr_wdata[rip_pkg::COUNT_WIDTH-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign pos_ext     = CMP_WIDTH'(position_ff);
   assign first_track = (track_index_ff == rip_pkg::FIRST_TRACK);
   assign last_track  = (track_index_ff == track_total_ff);
   assign short_track = (sample_count_ff < rip_pkg::SKIP_WORDS);
   assign hi_bound    = last_track ? sample_count_ff - rip_pkg::SKIP_WORDS : sample_count_ff;
   assign below_lo    = first_track && (pos_ext < CMP_WIDTH'(rip_pkg::SKIP_WORDS));
   assign above_hi    = pos_ext > CMP_WIDTH'(hi_bound);
   assign track_end   = pos_ext >= CMP_WIDTH'(sample_count_ff);

   assign q_push            = req_push && !q_full;
   assign q_word            = req_sample_word;
   assign q_pos             = position_ff;
   assign q_flags.in_window = !(last_track && short_track) && !below_lo && !above_hi;
   assign q_flags.track_end = track_end;

   always_comb begin
      position_in = position_ff;
      if (q_push) begin
         position_in = track_end ? POSITION_WIDTH'(1) : position_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         track_index_ff  <= rip_pkg::FIRST_TRACK;
         track_total_ff  <= rip_pkg::FIRST_TRACK;
         sample_count_ff <= '0;
         position_ff     <= POSITION_WIDTH'(1);
      end else begin
         track_index_ff  <= track_index_in;
         track_total_ff  <= track_total_in;
         sample_count_ff <= sample_count_in;
         position_ff     <= position_in;
      end
   end

endmodule

FILE: src/rip_back.sv
// Back end: sample-by-position multiply, sum accumulation and result queue.
module rip_back #(
   parameter int unsigned POSITION_WIDTH = 28
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            q_empty,
   input  logic [rip_pkg::WORD_WIDTH-1:0]  q_word,
   input  logic [POSITION_WIDTH-1:0]       q_pos,
   input  rip_pkg::item_flags_type         q_flags,
   output logic                            q_pop,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output logic [rip_pkg::SUM_WIDTH-1:0]   rsp_checksum_v1,
   output logic [rip_pkg::SUM_WIDTH-1:0]   rsp_checksum_v2,
   output rip_pkg::back_status_type        status
);

   localparam int unsigned PROD_WIDTH = rip_pkg::WORD_WIDTH + POSITION_WIDTH;
   localparam int unsigned OUT_DEPTH_LOG2 = 1;
   localparam int unsigned OUT_WIDTH = 2 * rip_pkg::SUM_WIDTH;

   logic [PROD_WIDTH-1:0]         prod_ff, prod_in;
   logic                          s1_valid_ff, s1_valid_in;
   rip_pkg::item_flags_type       s1_flags_ff, s1_flags_in;
   logic [rip_pkg::SUM_WIDTH-1:0] low_sum_ff, low_sum_in;
   logic [rip_pkg::SUM_WIDTH-1:0] high_sum_ff, high_sum_in;

   logic [rip_pkg::SUM_WIDTH-1:0] prod_lo, prod_hi, low_next, high_next, v2_next;
   logic                          s1_last, out_push, out_full, out_empty;
   logic [OUT_WIDTH-1:0]          out_data;

   // Hold a track end in the queue until the result queue has a free slot for it.
   assign s1_last = s1_valid_ff && s1_flags_ff.track_end;
   assign q_pop   = !q_empty && (!q_flags.track_end || (!out_full && !(s1_last && !out_empty)));

   always_comb begin
      s1_valid_in = q_pop;
      s1_flags_in = q_flags;
      prod_in     = PROD_WIDTH'(q_word) * PROD_WIDTH'(q_pos);
   end

   assign prod_lo   = s1_flags_ff.in_window ? prod_ff[rip_pkg::SUM_WIDTH-1:0] : '0;
   assign prod_hi   = s1_flags_ff.in_window ?
                      rip_pkg::SUM_WIDTH'(prod_ff[PROD_WIDTH-1:rip_pkg::SUM_WIDTH]) : '0;
   assign low_next  = low_sum_ff + prod_lo;
   assign high_next = high_sum_ff + prod_hi;
   assign v2_next   = low_next + high_next;
   assign out_push  = s1_last;
   assign out_data  = {low_next, v2_next};

   always_comb begin
      low_sum_in  = low_sum_ff;
      high_sum_in = high_sum_ff;
      if (s1_valid_ff) begin
         if (s1_flags_ff.track_end) begin
            low_sum_in  = '0;
            high_sum_in = '0;
         end else begin
            low_sum_in  = low_next;
            high_sum_in = high_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         low_sum_ff  <= '0;
         high_sum_ff <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         low_sum_ff  <= low_sum_in;
         high_sum_ff <= high_sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         prod_ff     <= prod_in;
         s1_flags_ff <= s1_flags_in;
      end
   end

   rip_fifo #(
      .WIDTH      (OUT_WIDTH),
      .DEPTH_LOG2 (OUT_DEPTH_LOG2)
   ) u_result_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_data),
      .pop       (rsp_pop),
      .pop_data  ({rsp_checksum_v1, rsp_checksum_v2}),
      .full      (out_full),
      .empty     (out_empty)
   );

   assign rsp_empty          = out_empty;
   assign status.result_push = out_push;
   assign status.result_full = out_full;

endmodule

FILE: test/rip_checksum_checker.sv
// Checker for the track rip checksum block: predicts each track's checksums and compares them.
module rip_checksum_checker #(
   parameter int unsigned POSITION_WIDTH = 28
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [rip_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [rip_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   input  logic                                req_push,
   input  logic                                req_full,
   input  logic [rip_pkg::WORD_WIDTH-1:0]      req_sample_word,
   input  logic                                rsp_empty,
   input  logic                                rsp_pop,
   input  logic [rip_pkg::SUM_WIDTH-1:0]       rsp_checksum_v1,
   input  logic [rip_pkg::SUM_WIDTH-1:0]       rsp_checksum_v2,
   output int                                  fail_count,
   output int                                  pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [rip_pkg::SUM_WIDTH-1:0] v1;
      logic [rip_pkg::SUM_WIDTH-1:0] v2;
   } checksum_pair_type;

   logic [rip_pkg::TRACK_WIDTH-1:0] track_index_q;
   logic [rip_pkg::TRACK_WIDTH-1:0] track_total_q;
   logic [rip_pkg::COUNT_WIDTH-1:0] sample_count_q;
   logic [POSITION_WIDTH-1:0]       position_q;
   logic [rip_pkg::SUM_WIDTH-1:0]   low_sum_q;
   logic [rip_pkg::SUM_WIDTH-1:0]   high_sum_q;
   checksum_pair_type               checksum_queue[$];
   checksum_pair_type               oldest_pair;

   function automatic void clear_track();
      position_q = POSITION_WIDTH'(1);
      low_sum_q = '0;
      high_sum_q = '0;
   endfunction

   function automatic void accumulate_sample(input logic [rip_pkg::WORD_WIDTH-1:0] word);
      logic [63:0] product;
      logic [63:0] lo_bound;
      logic [63:0] hi_bound;
      logic [63:0] pos;
      logic        window_open;
      pos = 64'(position_q);
      lo_bound = (track_index_q == rip_pkg::FIRST_TRACK) ? 64'(rip_pkg::SKIP_WORDS) : 64'd0;
      hi_bound = 64'(sample_count_q);
      window_open = 1'b1;
      if (track_index_q == track_total_q) begin
         if (sample_count_q < rip_pkg::SKIP_WORDS) begin
            window_open = 1'b0;
         end else begin
            hi_bound = 64'(sample_count_q - rip_pkg::SKIP_WORDS);
         end
      end
      if (window_open && pos >= lo_bound && pos <= hi_bound) begin
         product = 64'(word) * pos;
         low_sum_q = low_sum_q + product[31:0];
         high_sum_q = high_sum_q + product[63:32];
      end
      if (pos >= 64'(sample_count_q)) begin
         checksum_queue.push_back('{v1: low_sum_q, v2: low_sum_q + high_sum_q});
         clear_track();
      end else begin
         position_q = position_q + 1'b1;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         track_index_q = rip_pkg::TRACK_WIDTH'(1);
         track_total_q = rip_pkg::TRACK_WIDTH'(1);
         sample_count_q = '0;
         clear_track();
         checksum_queue.delete();
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (checksum_queue.size() == 0) begin
               $display("%0t: unexpected checksum: expected none, actual v1 %h v2 %h",
                        $time, rsp_checksum_v1, rsp_checksum_v2);
               fail_count = fail_count + 1;
            end else begin
               oldest_pair = checksum_queue.pop_front();
               if (rsp_checksum_v1 !== oldest_pair.v1) begin
                  $display("%0t: checksum_v1 mismatch: expected %h, actual %h",
                           $time, oldest_pair.v1, rsp_checksum_v1);
                  fail_count = fail_count + 1;
               end
               if (rsp_checksum_v2 !== oldest_pair.v2) begin
                  $display("%0t: checksum_v2 mismatch: expected %h, actual %h",
                           $time, oldest_pair.v2, rsp_checksum_v2);
                  fail_count = fail_count + 1;
               end
            end
         end
         if (csr_write_en) begin
            case (csr_index)
               rip_pkg::CSR_TRACK_INDEX: begin
                  track_index_q = csr_wdata[rip_pkg::TRACK_WIDTH-1:0];
               end
               rip_pkg::CSR_TRACK_TOTAL: begin
                  track_total_q = csr_wdata[rip_pkg::TRACK_WIDTH-1:0];
               end
               rip_pkg::CSR_SAMPLE_COUNT: begin
                  sample_count_q = csr_wdata[rip_pkg::COUNT_WIDTH-1:0];
               end
               default: begin
               end
            endcase
         end
         if (req_push && !req_full) begin
            accumulate_sample(req_sample_word);
         end
      end
      pending <= checksum_queue.size();
   end

endmodule

FILE: test/tb_cd_track_rip_checksum.sv
// Testbench top for the track rip checksum block: clock, reset, stimulus and verdict.
module tb_cd_track_rip_checksum;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [rip_pkg::CSR_INDEX_WIDTH-1:0] CSR_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 8;
   localparam int MAX_COUNT = 268435455;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                csr_write_en = 1'b0;
   logic [rip_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [rip_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata = '0;
   logic                                req_push = 1'b0;
   logic                                req_full;
   logic [rip_pkg::WORD_WIDTH-1:0]      req_sample_word = '0;
   logic                                rsp_empty;
   logic                                rsp_pop = 1'b0;
   logic [rip_pkg::SUM_WIDTH-1:0]       rsp_checksum_v1;
   logic [rip_pkg::SUM_WIDTH-1:0]       rsp_checksum_v2;
   int                                  fail_count;
   int                                  pending;
   int                                  cycle_count = 0;
   int                                  samples_sent = 0;
   int                                  tracks_done = 0;
   logic                                steady = 1'b0;

   cd_track_rip_checksum uut (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_sample_word (req_sample_word),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_checksum_v1 (rsp_checksum_v1),
      .rsp_checksum_v2 (rsp_checksum_v2)
   );

   rip_checksum_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_sample_word (req_sample_word),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_checksum_v1 (rsp_checksum_v1),
      .rsp_checksum_v2 (rsp_checksum_v2),
      .fail_count      (fail_count),
      .pending         (pending)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_pop <= steady || ($urandom_range(0, 99) >= 34);
   end

   function automatic logic [rip_pkg::WORD_WIDTH-1:0] pick_word();
      case ($urandom_range(0, 15))
         0: pick_word = '0;
         1: pick_word = '1;
         default: pick_word = $urandom;
      endcase
   endfunction

   task automatic send_sample(input logic [rip_pkg::WORD_WIDTH-1:0] word);
      while (!steady && $urandom_range(0, 99) < 34) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_sample_word <= word;
      @(posedge clock);
      while (req_full) @(posedge clock);
      samples_sent++;
   endtask

   // hold input until every checksum is out and the pipeline is empty
   task automatic drain_checksums();
      req_push <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic put_reg(input logic [rip_pkg::CSR_INDEX_WIDTH-1:0] index,
                          input logic [rip_pkg::CSR_DATA_WIDTH-1:0] value);
      csr_write_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic program_track(input int unsigned track_no, input int unsigned track_cnt,
                                input int unsigned samples);
      drain_checksums();
      put_reg(rip_pkg::CSR_TRACK_INDEX, rip_pkg::CSR_DATA_WIDTH'(track_no));
      put_reg(rip_pkg::CSR_TRACK_TOTAL, rip_pkg::CSR_DATA_WIDTH'(track_cnt));
      put_reg(rip_pkg::CSR_SAMPLE_COUNT, rip_pkg::CSR_DATA_WIDTH'(samples));
      csr_write_en <= 1'b0;
   endtask

   task automatic run_track(input int unsigned track_no, input int unsigned track_cnt,
                            input int unsigned samples);
      program_track(track_no, track_cnt, samples);
      repeat ((samples == 0) ? 1 : samples) send_sample(pick_word());
      tracks_done++;
   endtask

   // start a long track, then lower sample_count below the position to end it early
   task automatic cut_track(input int unsigned track_no, input int unsigned track_cnt,
                            input int unsigned samples, input int unsigned lead);
      program_track(track_no, track_cnt, samples);
      repeat (lead) send_sample(pick_word());
      drain_checksums();
      put_reg(rip_pkg::CSR_SAMPLE_COUNT, rip_pkg::CSR_DATA_WIDTH'($urandom_range(0, lead)));
      csr_write_en <= 1'b0;
      send_sample(pick_word());
      tracks_done++;
   endtask

   initial begin
      int unsigned roll;
      int unsigned ti;
      int unsigned tt;
      int          track_no;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // zero sample_count after reset: every request ends a track
      send_sample('1);
      program_track(5, 9, 3);
      send_sample('1);
      send_sample('0);
      send_sample(32'h8000_0000);
      send_sample('1);
      program_track(1, 9, 4);
      repeat (4) send_sample('1);
      program_track(9, 9, 2);
      send_sample('1);
      send_sample(32'h7FFF_FFFF);
      drain_checksums();
      put_reg(CSR_UNUSED, '1);
      put_reg(rip_pkg::CSR_TRACK_INDEX, 28'hFFF_FF80);
      put_reg(rip_pkg::CSR_TRACK_TOTAL, '1);
      put_reg(rip_pkg::CSR_SAMPLE_COUNT, 28'd2);
      csr_write_en <= 1'b0;
      send_sample(32'h0000_FFFF);
      send_sample(32'hFFFF_0000);
      program_track(3, 4, MAX_COUNT);
      repeat (3) send_sample('1);
      drain_checksums();
      put_reg(rip_pkg::CSR_SAMPLE_COUNT, 28'd1);
      csr_write_en <= 1'b0;
      send_sample('1);

      track_no = 0;
      while (samples_sent < 950 || tracks_done < 40) begin
         steady = (track_no >= 10 && track_no < 16);
         roll = $urandom_range(0, 99);
         tt = $urandom_range(3, 99);
         ti = $urandom_range(2, tt - 1);
         if (track_no == 3) begin
            cut_track(tt, tt, $urandom_range(2941, 2950), $urandom_range(1, 20));
         end else if (track_no == 20) begin
            cut_track(tt, tt, $urandom_range(2941, 2990), $urandom_range(1, 10));
         end else if (track_no == 30) begin
            cut_track(1, 1, $urandom_range(5880, 5900), $urandom_range(1, 10));
         end else if (roll < 10) begin
            cut_track(ti, tt, $urandom_range(1 << 20, MAX_COUNT), $urandom_range(1, 10));
         end else if (roll < 18) begin
            run_track($urandom_range(0, MAX_COUNT), $urandom_range(0, MAX_COUNT),
                      $urandom_range(0, 8));
         end else if (roll < 26) begin
            run_track(ti, tt, 0);
         end else if (roll < 36) begin
            run_track(1, tt, $urandom_range(1, 30));
         end else if (roll < 46) begin
            run_track(tt, tt, $urandom_range(1, 30));
         end else begin
            run_track(ti, tt, $urandom_range(1, 40));
         end
         track_no++;
      end
      steady = 1'b0;

      drain_checksums();
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

FILE: cd_track_rip_checksum.f
src/rip_pkg.sv
src/rip_fifo.sv
src/rip_front.sv
src/rip_back.sv
src/cd_track_rip_checksum.sv
test/rip_checksum_checker.sv
test/tb_cd_track_rip_checksum.sv
